// File: src/dedup_bounded_suspect_set_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deduplicating bounded set
// Shared property wrappers; clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DEDUP_BOUNDED_SUSPECT_SET_MACROS_SVH
`define DEDUP_BOUNDED_SUSPECT_SET_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DBSS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DBSS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/dbss_pkg.sv
// ---------------------------------------------------------------------------
// dbss_pkg
// Shared constants, codes and types for the deduplicating bounded set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbss_pkg;

  // sizing
  localparam int CAP    = 32;
  localparam int ADDR_W = 48;
  localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int CFG_W  = 6;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;

  // request and result packing
  localparam int IN_FIELDS_W  = FUNC_W + ADDR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + 1 + ADDR_W + CFG_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DRAIN  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd5;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd6;

  // configuration register indexes
  localparam logic REG_MAX_ENTRIES   = 1'b0;
  localparam logic REG_TRIGGER_LEVEL = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_EXEC,
    S_DRAIN
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              srch;   // latch compare result
    logic              shift;  // take entry from upper neighbor
    logic [ADDR_W-1:0] key;    // search key
    logic [ADDR_W-1:0] wdata;  // data for a targeted write
  } cell_bus_t;

endpackage

// File: src/dedup_bounded_suspect_set.sv
// Deduplicating bounded set: ordered address set with no duplicates and a size limit.
// Add, remove, query and clear: each request does a key compare in every cell,
// then update; a new request is taken in the update cycle when the result register is free.
// Drain: compare, update, then one result per held entry, shifted out of the cell chain.
// Reset: count cleared, max_entries = 32, trigger_level = 16; slot contents undefined.
// ---------------------------------------------------------------------------
// dedup_bounded_suspect_set
// Top level: request register, sequencer, chain of cells and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dedup_bounded_suspect_set_macros.svh"

module dedup_bounded_suspect_set (
  input  logic                               clk,
  input  logic                               rst,
  // request: [2:0] func, [50:3] object, rest zero
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dbss_pkg::IN_DATA_W-1:0]     s_tdata,
  // result: [2:0] status, [3] is_member, [51:4] entry, [57:52] count,
  //         [58] trigger, [59] empty_res, rest zero
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dbss_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser,  // [0] entry_valid
  output logic                               m_tlast,
  // configuration
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [dbss_pkg::CFG_W-1:0]         cfg_data
);

  dbss_pkg::state_t                 state, state_next;
  logic [dbss_pkg::CFG_W-1:0]       max_entries, trigger_level;
  logic [dbss_pkg::CNT_W-1:0]       count, count_next;
  logic [dbss_pkg::CNT_W-1:0]       dcnt;
  logic [dbss_pkg::FUNC_W-1:0]      func_q;
  logic [dbss_pkg::ADDR_W-1:0]      key_q;
  logic [dbss_pkg::ADDR_W-1:0]      lastent;
  logic [dbss_pkg::ADDR_W-1:0]      entries [dbss_pkg::CAP];
  logic [dbss_pkg::CAP-1:0]         hit_vec, wr_vec, occ_vec;
  logic [dbss_pkg::CNT_W-1:0]       cnt_m1;
  logic [dbss_pkg::CNT_W-1:0]       lim;
  dbss_pkg::cell_bus_t              bus;
  logic                             seq_srch, seq_shift;
  logic                             s_acc, out_free, commit, drain_go, load_out;
  logic                             hit_any, key_null, add_ok, rem_ok;
  logic [dbss_pkg::STAT_W-1:0]      res_status;
  logic                             res_member;
  logic [dbss_pkg::STAT_W-1:0]      o_status;
  logic                             o_member, o_trigger, o_empty;
  logic [dbss_pkg::ADDR_W-1:0]      o_entry;
  logic [dbss_pkg::CNT_W-1:0]       o_count;
  logic [dbss_pkg::CNT_W-1:0]       res_count;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign hit_any  = |hit_vec;
  assign key_null = (key_q == '0);
  assign cnt_m1   = count - dbss_pkg::CNT_W'(1);

  // effective limit: smaller of max_entries and capacity
  always_comb begin
    if (int'(max_entries) >= dbss_pkg::CAP) begin
      lim = dbss_pkg::CNT_W'(dbss_pkg::CAP);
    end else begin
      lim = dbss_pkg::CNT_W'(max_entries);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries   <= dbss_pkg::CFG_W'(32);
      trigger_level <= dbss_pkg::CFG_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        dbss_pkg::REG_MAX_ENTRIES:   max_entries   <= cfg_data;
        dbss_pkg::REG_TRIGGER_LEVEL: trigger_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (s_acc) begin
      func_q <= s_tdata[dbss_pkg::FUNC_W-1:0];
      key_q  <= s_tdata[dbss_pkg::FUNC_W +: dbss_pkg::ADDR_W];
    end
  end

  // last occupied slot, read during the compare cycle
  always_ff @(posedge clk) begin
    if (state == dbss_pkg::S_SRCH) begin
      lastent <= entries[cnt_m1[dbss_pkg::IDX_W-1:0]];
    end
  end

  // operation decode for the update cycle
  always_comb begin
    add_ok     = 1'b0;
    rem_ok     = 1'b0;
    res_status = dbss_pkg::ST_DONE;
    res_member = 1'b0;
    res_count  = count;
    case (func_q)
      dbss_pkg::FN_ADD: begin
        if (key_null) begin
          res_status = dbss_pkg::ST_NULL;
        end else if (hit_any) begin
          res_status = dbss_pkg::ST_DUP;
        end else if (count >= lim) begin
          res_status = dbss_pkg::ST_FULL;
        end else begin
          res_status = dbss_pkg::ST_ADDED;
          add_ok     = 1'b1;
          res_count  = count + dbss_pkg::CNT_W'(1);
        end
      end
      dbss_pkg::FN_REMOVE: begin
        if (key_null) begin
          res_status = dbss_pkg::ST_NULL;
        end else if (!hit_any) begin
          res_status = dbss_pkg::ST_ABSENT;
        end else begin
          res_status = dbss_pkg::ST_REMOVED;
          rem_ok     = 1'b1;
          res_count  = cnt_m1;
        end
      end
      dbss_pkg::FN_QUERY: begin
        res_member = !key_null && hit_any;
      end
      dbss_pkg::FN_DRAIN: begin
        res_count = '0;
      end
      dbss_pkg::FN_CLEAR: begin
        res_count = '0;
      end
      default: ;
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      dbss_pkg::S_IDLE: begin
        if (s_tvalid) state_next = dbss_pkg::S_SRCH;
      end
      dbss_pkg::S_SRCH: begin
        state_next = dbss_pkg::S_EXEC;
      end
      dbss_pkg::S_EXEC: begin
        if (out_free) begin
          if (func_q == dbss_pkg::FN_DRAIN && count != '0) begin
            state_next = dbss_pkg::S_DRAIN;
          end else if (s_tvalid) begin
            state_next = dbss_pkg::S_SRCH;
          end else begin
            state_next = dbss_pkg::S_IDLE;
          end
        end
      end
      dbss_pkg::S_DRAIN: begin
        if (out_free && dcnt == dbss_pkg::CNT_W'(1)) state_next = dbss_pkg::S_IDLE;
      end
      default: state_next = dbss_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    commit    = 1'b0;
    drain_go  = 1'b0;
    s_tready  = 1'b0;
    seq_srch  = 1'b0;
    seq_shift = 1'b0;
    case (state)
      dbss_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      dbss_pkg::S_SRCH: begin
        seq_srch = 1'b1;
      end
      dbss_pkg::S_EXEC: begin
        commit   = out_free;
        drain_go = out_free && func_q == dbss_pkg::FN_DRAIN && count != '0;
        s_tready = out_free && !(func_q == dbss_pkg::FN_DRAIN && count != '0);
      end
      dbss_pkg::S_DRAIN: begin
        seq_shift = out_free;
      end
      default: ;
    endcase
  end

  // broadcast to the cells: srch, shift, key, wdata
  assign bus      = {seq_srch, seq_shift, key_q,
                     (func_q == dbss_pkg::FN_ADD) ? key_q : lastent};
  assign load_out = (commit && !drain_go) || bus.shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry count and drain counter
  assign count_next = commit ? res_count : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dcnt  <= '0;
    end else begin
      count <= count_next;
      if (drain_go) begin
        dcnt <= count;
      end else if (bus.shift) begin
        dcnt <= dcnt - dbss_pkg::CNT_W'(1);
      end
    end
  end

  // chain of cells
  for (genvar i = 0; i < dbss_pkg::CAP; i++) begin : g_cell
    logic [dbss_pkg::ADDR_W-1:0] nbr;
    if (i == dbss_pkg::CAP - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[i+1];
    end
    assign occ_vec[i] = (int'(count) > i);
    assign wr_vec[i]  = commit && ((add_ok && count[dbss_pkg::IDX_W-1:0] ==
                                    dbss_pkg::IDX_W'(i)) || (rem_ok && hit_vec[i]));
    dbss_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .bus   (bus),
      .wr    (wr_vec[i]),
      .occ   (occ_vec[i]),
      .nbr   (nbr),
      .entry (entries[i]),
      .hit   (hit_vec[i])
    );
  end

  // result fields
  always_comb begin
    if (state == dbss_pkg::S_DRAIN) begin
      o_status = dbss_pkg::ST_DONE;
      o_member = 1'b0;
      o_entry  = entries[0];
      o_count  = count;
    end else begin
      o_status = res_status;
      o_member = res_member;
      o_entry  = '0;
      o_count  = res_count;
    end
    o_trigger = int'(o_count) >= int'(trigger_level);
    o_empty   = (o_count == '0);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= dbss_pkg::OUT_DATA_W'({o_empty, o_trigger,
                                        dbss_pkg::CFG_W'(o_count), o_entry,
                                        o_member, o_status});
      m_tuser <= (state == dbss_pkg::S_DRAIN);
      m_tlast <= (state != dbss_pkg::S_DRAIN) || (dcnt == dbss_pkg::CNT_W'(1));
    end
  end

  // checks
  `DBSS_ASSERT_IMP(a_hit_unique, state == dbss_pkg::S_EXEC, $onehot0(hit_vec),
                   "duplicate entries matched")
  `DBSS_ASSERT_IMP(a_count_cap, 1'b1, int'(count) <= dbss_pkg::CAP,
                   "count above capacity")
  `DBSS_ASSERT_IMP(a_drain_empty, state == dbss_pkg::S_DRAIN, count == '0 && dcnt != '0,
                   "drain state inconsistent")
  `DBSS_ASSERT_NXT(a_drain_end,
                   state == dbss_pkg::S_DRAIN && out_free && dcnt == dbss_pkg::CNT_W'(1),
                   m_tvalid && m_tlast && state == dbss_pkg::S_IDLE,
                   "drain did not end with last")
  `DBSS_ASSERT_NXT(a_exec_take, state == dbss_pkg::S_EXEC && s_acc,
                   state == dbss_pkg::S_SRCH, "request taken in update cycle not searched")

endmodule

// File: src/dbss_cell.sv
// ---------------------------------------------------------------------------
// dbss_cell
// One slot of the set: holds an address, compares it against the broadcast
// key and hands its address to the lower neighbor during a drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbss_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  dbss_pkg::cell_bus_t           bus,
  input  logic                          wr,     // targeted write of bus.wdata
  input  logic                          occ,    // slot is below the count
  input  logic [dbss_pkg::ADDR_W-1:0]   nbr,    // entry of the upper neighbor
  output logic [dbss_pkg::ADDR_W-1:0]   entry,
  output logic                          hit
);

  // slot contents: shift wins, then targeted write
  always_ff @(posedge clk) begin
    if (bus.shift) begin
      entry <= nbr;
    end else if (wr) begin
      entry <= bus.wdata;
    end
  end

  // registered match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (bus.srch) begin
      hit <= occ && (entry == bus.key);
    end
  end

endmodule

// File: tb/dedup_bounded_suspect_set_tb.sv
// ---------------------------------------------------------------------------
// dedup_bounded_suspect_set_tb
// Stream testbench for the deduplicating bounded set. A directed opening
// covers null, duplicate, absent and move-on-remove cases, drains and clear.
// Random phases follow under a range of limits and trigger levels. Both
// stream sides get random gaps. A local copy of the set predicts every
// result, and each returned result is compared against it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dedup_bounded_suspect_set_tb;

  // spare operation codes, treated by the block as no-ops
  localparam logic [dbss_pkg::FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [dbss_pkg::FUNC_W-1:0] FN_SPARE_MID   = 3'd6;
  localparam logic [dbss_pkg::FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

  // result field positions in m_tdata
  localparam int POS_MEMBER = dbss_pkg::STAT_W;
  localparam int POS_ENTRY  = dbss_pkg::STAT_W + 1;
  localparam int POS_COUNT  = POS_ENTRY + dbss_pkg::ADDR_W;
  localparam int POS_TRIG   = POS_COUNT + dbss_pkg::CNT_W;
  localparam int POS_EMPTY  = POS_TRIG + 1;

  localparam int POOL_SIZE   = 40;
  localparam int MAX_GAP     = 8;
  localparam int SETTLE_CYC  = 8;
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [dbss_pkg::ADDR_W-1:0] ADDR_ONES = '1;
  localparam logic [dbss_pkg::ADDR_W-1:0] ADDR_TOP  = {1'b1, {(dbss_pkg::ADDR_W-1){1'b0}}};
  localparam logic [dbss_pkg::ADDR_W-1:0] ADDR_ONE  = dbss_pkg::ADDR_W'(1);

  typedef struct packed {
    logic [dbss_pkg::FUNC_W-1:0] func;
    logic [dbss_pkg::ADDR_W-1:0] object;
  } request_t;

  typedef struct packed {
    logic [dbss_pkg::STAT_W-1:0] status;
    logic                        is_member;
    logic [dbss_pkg::ADDR_W-1:0] entry;
    logic                        entry_valid;
    logic                        last;
    logic [dbss_pkg::CNT_W-1:0]  count;
    logic                        trigger;
    logic                        empty_res;
  } outcome_t;

  // DUT ports
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [dbss_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [dbss_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = dbss_pkg::REG_MAX_ENTRIES;
  logic [dbss_pkg::CFG_W-1:0]      cfg_data = '0;

  // stimulus and expectation stores
  request_t                    pending_reqs[$];
  outcome_t                    expected_outcomes[$];
  logic [dbss_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];

  // shadow of the set and its registers
  logic [dbss_pkg::ADDR_W-1:0] shadow_slots[dbss_pkg::CAP];
  int                          shadow_count;
  logic [dbss_pkg::CFG_W-1:0]  shadow_max;
  logic [dbss_pkg::CFG_W-1:0]  shadow_trig;

  int       fail_count;
  int       cycle_count;
  request_t tx_req;
  int       tx_wait;
  int       rx_wait;
  bit       tx_calm;
  bit       rx_calm;
  logic     tx_next;

  dedup_bounded_suspect_set dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [2:0] func, [50:3] object
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [2:0] status, [3] is_member, [51:4] entry,
                            // [57:52] count, [58] trigger, [59] empty_res
    .m_tuser   (m_tuser),   // [0] entry_valid
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [dbss_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[dbss_pkg::ADDR_W-1:0];
  endfunction

  // gap before the next request or result; quiet stretches come and go
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int find_slot(logic [dbss_pkg::ADDR_W-1:0] addr);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_slots[i] == addr) return i;
    return -1;
  endfunction

  // queue one expected result; count fields reflect the set after the step
  task automatic push_outcome(logic [dbss_pkg::STAT_W-1:0] status, logic member,
                              logic [dbss_pkg::ADDR_W-1:0] entry, logic valid,
                              logic last);
    outcome_t o;
    o.status      = status;
    o.is_member   = member;
    o.entry       = entry;
    o.entry_valid = valid;
    o.last        = last;
    o.count       = shadow_count[dbss_pkg::CNT_W-1:0];
    o.trigger     = (shadow_count >= int'(shadow_trig));
    o.empty_res   = (shadow_count == 0);
    expected_outcomes.insert(expected_outcomes.size(), o);
  endtask

  // apply one accepted request to the shadow set and queue its results
  task automatic apply_request(request_t r);
    int                          slot;
    int                          held;
    int                          limit;
    logic [dbss_pkg::STAT_W-1:0] status;
    slot  = find_slot(r.object);
    limit = (int'(shadow_max) < dbss_pkg::CAP) ? int'(shadow_max) : dbss_pkg::CAP;
    case (r.func)
      dbss_pkg::FN_ADD: begin
        if (r.object == '0) status = dbss_pkg::ST_NULL;
        else if (slot >= 0) status = dbss_pkg::ST_DUP;
        else if (shadow_count >= limit) status = dbss_pkg::ST_FULL;
        else begin
          shadow_slots[shadow_count] = r.object;
          shadow_count++;
          status = dbss_pkg::ST_ADDED;
        end
        push_outcome(status, 1'b0, '0, 1'b0, 1'b1);
      end
      dbss_pkg::FN_REMOVE: begin
        if (r.object == '0) status = dbss_pkg::ST_NULL;
        else if (slot < 0) status = dbss_pkg::ST_ABSENT;
        else begin
          // last entry fills the hole
          shadow_count--;
          shadow_slots[slot] = shadow_slots[shadow_count];
          status = dbss_pkg::ST_REMOVED;
        end
        push_outcome(status, 1'b0, '0, 1'b0, 1'b1);
      end
      dbss_pkg::FN_QUERY: begin
        push_outcome(dbss_pkg::ST_DONE, (r.object != '0) && (slot >= 0), '0, 1'b0, 1'b1);
      end
      dbss_pkg::FN_DRAIN: begin
        held = shadow_count;
        shadow_count = 0;
        if (held == 0) push_outcome(dbss_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1);
        for (int i = 0; i < held; i++)
          push_outcome(dbss_pkg::ST_DONE, 1'b0, shadow_slots[i], 1'b1, i == held - 1);
      end
      dbss_pkg::FN_CLEAR: begin
        shadow_count = 0;
        push_outcome(dbss_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1);
      end
      default: begin
        push_outcome(dbss_pkg::ST_DONE, 1'b0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic check_outcome();
    outcome_t got;
    outcome_t want;
    got.status      = m_tdata[dbss_pkg::STAT_W-1:0];
    got.is_member   = m_tdata[POS_MEMBER];
    got.entry       = m_tdata[POS_ENTRY +: dbss_pkg::ADDR_W];
    got.entry_valid = m_tuser;
    got.last        = m_tlast;
    got.count       = m_tdata[POS_COUNT +: dbss_pkg::CNT_W];
    got.trigger     = m_tdata[POS_TRIG];
    got.empty_res   = m_tdata[POS_EMPTY];
    if (expected_outcomes.size() == 0) begin
      $error("unexpected result: status 0x%0h, count %0d", got.status, got.count);
      fail_count++;
    end else begin
      want = expected_outcomes.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("is_member", 64'(want.is_member), 64'(got.is_member));
      check_field("entry", 64'(want.entry), 64'(got.entry));
      check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
      check_field("last", 64'(want.last), 64'(got.last));
      check_field("count", 64'(want.count), 64'(got.count));
      check_field("trigger", 64'(want.trigger), 64'(got.trigger));
      check_field("empty_res", 64'(want.empty_res), 64'(got.empty_res));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_wait  = 0;
    end else begin
      tx_next = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_request(tx_req);
        tx_next = 1'b0;
        tx_wait = draw_gap(tx_calm);
      end
      if (!tx_next) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_reqs.size() != 0) begin
          tx_req = pending_reqs.pop_front();
          s_tdata <= {{(dbss_pkg::IN_DATA_W - dbss_pkg::FUNC_W - dbss_pkg::ADDR_W){1'b0}},
                      tx_req.object, tx_req.func};
          tx_next = 1'b1;
        end
      end
      s_tvalid <= tx_next;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_outcome();
        rx_wait = draw_gap(rx_calm);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_req(logic [dbss_pkg::FUNC_W-1:0] func,
                          logic [dbss_pkg::ADDR_W-1:0] object);
    request_t r;
    r.func   = func;
    r.object = object;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // register write; only called while the block is idle
  task automatic write_reg(logic idx, logic [dbss_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == dbss_pkg::REG_MAX_ENTRIES) shadow_max = value;
    else shadow_trig = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(logic [dbss_pkg::CFG_W-1:0] max_val,
                            logic [dbss_pkg::CFG_W-1:0] trig_val);
    write_reg(dbss_pkg::REG_MAX_ENTRIES, max_val);
    write_reg(dbss_pkg::REG_TRIGGER_LEVEL, trig_val);
    @(negedge clk);
  endtask

  // random requests; fill mode favors adds so the set reaches its limit
  task automatic queue_random(int n, bit fill);
    int                          pick;
    logic [dbss_pkg::FUNC_W-1:0] fn;
    logic [dbss_pkg::ADDR_W-1:0] obj;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (fill) begin
        if (pick < 75) fn = dbss_pkg::FN_ADD;
        else if (pick < 83) fn = dbss_pkg::FN_REMOVE;
        else if (pick < 97) fn = dbss_pkg::FN_QUERY;
        else if (pick < 99) fn = dbss_pkg::FN_DRAIN;
        else fn = dbss_pkg::FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
      end else begin
        if (pick < 51) fn = dbss_pkg::FN_ADD;
        else if (pick < 69) fn = dbss_pkg::FN_REMOVE;
        else if (pick < 87) fn = dbss_pkg::FN_QUERY;
        else if (pick < 94) fn = dbss_pkg::FN_DRAIN;
        else if (pick < 97) fn = dbss_pkg::FN_CLEAR;
        else fn = dbss_pkg::FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) obj = '0;
      else if (pick < 18) obj = rand_addr();
      else obj = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      push_req(fn, obj);
    end
  endtask

  // wait until every request is sent and every result is back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // main sequence
  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    shadow_count = 0;
    shadow_max   = 6'd32;
    shadow_trig  = 6'd16;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    addr_pool[0] = ADDR_ONES;
    addr_pool[1] = ADDR_ONE;
    for (int i = 2; i < POOL_SIZE; i++) begin
      addr_pool[i] = rand_addr();
      if (addr_pool[i] == '0) addr_pool[i] = ADDR_TOP;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening under reset settings
    push_req(dbss_pkg::FN_DRAIN, '0);            // drain of empty set
    push_req(dbss_pkg::FN_ADD, '0);              // null add
    push_req(dbss_pkg::FN_REMOVE, '0);           // null remove
    push_req(dbss_pkg::FN_QUERY, '0);            // null never a member
    push_req(dbss_pkg::FN_ADD, ADDR_ONES);
    push_req(dbss_pkg::FN_ADD, ADDR_ONES);       // duplicate
    push_req(dbss_pkg::FN_ADD, ADDR_ONE);
    push_req(dbss_pkg::FN_ADD, ADDR_TOP);
    push_req(dbss_pkg::FN_QUERY, ADDR_ONES);
    push_req(dbss_pkg::FN_QUERY, addr_pool[5]);  // absent
    push_req(dbss_pkg::FN_REMOVE, addr_pool[5]); // absent
    push_req(dbss_pkg::FN_REMOVE, ADDR_ONES);    // last entry moves into slot 0
    push_req(dbss_pkg::FN_QUERY, ADDR_TOP);
    push_req(dbss_pkg::FN_DRAIN, ADDR_ONES);     // two entries, moved order
    push_req(dbss_pkg::FN_QUERY, ADDR_ONE);
    push_req(dbss_pkg::FN_ADD, addr_pool[7]);
    push_req(dbss_pkg::FN_CLEAR, '0);
    push_req(dbss_pkg::FN_DRAIN, '0);
    push_req(FN_SPARE_FIRST, ADDR_ONES);
    push_req(FN_SPARE_MID, addr_pool[3]);
    push_req(FN_SPARE_LAST, '0);
    wait_idle();

    // tiny limit: duplicate and null win over full
    set_limits(6'd2, 6'd1);
    push_req(dbss_pkg::FN_ADD, addr_pool[10]);
    push_req(dbss_pkg::FN_ADD, addr_pool[11]);
    push_req(dbss_pkg::FN_ADD, addr_pool[11]);
    push_req(dbss_pkg::FN_ADD, addr_pool[12]);
    push_req(dbss_pkg::FN_ADD, '0);
    queue_random(30, 1'b0);
    wait_idle();

    // zero limit refuses every add; trigger level zero always fires
    set_limits(6'd0, 6'd0);
    queue_random(25, 1'b0);
    wait_idle();

    // limit above capacity, highest trigger level
    set_limits(6'd63, 6'd63);
    queue_random(70, 1'b1);
    wait_idle();

    set_limits(6'd32, 6'd32);
    queue_random(60, 1'b1);
    wait_idle();

    set_limits(6'd40, 6'd33);
    queue_random(50, 1'b1);
    wait_idle();

    set_limits(6'd8, 6'd5);
    queue_random(50, 1'b0);
    wait_idle();

    set_limits(dbss_pkg::CFG_W'($urandom_range(0, 63)),
               dbss_pkg::CFG_W'($urandom_range(0, 63)));
    queue_random(80, 1'b0);
    wait_idle();

    set_limits(6'd1, 6'd63);
    queue_random(30, 1'b0);
    wait_idle();

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/dbss_pkg.sv
src/dbss_cell.sv
src/dedup_bounded_suspect_set.sv
tb/dedup_bounded_suspect_set_tb.sv
